@@ hw/rtl/voxel_face_mesher_ao_macros.svh @@
// Assertion macros for the voxel face mesher RTL.
// Included by voxel_face_mesher_ao, the module that carries concurrent assertions; no other dependencies.
`ifndef VOXEL_FACE_MESHER_AO_MACROS_SVH
`define VOXEL_FACE_MESHER_AO_MACROS_SVH
`ifndef ASSERT_OFF
`define VFM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VFM_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define VFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/vfm_pkg.sv @@
`timescale 1ns / 1ps
// Types, constants and neighbor tables for the voxel face mesher.
// No dependencies; imported by every module of the block.
package vfm_pkg;

   localparam int FACE_COUNT   = 6;
   localparam int CORNER_COUNT = 4;
   localparam int VTX_PER_FACE = 6;
   localparam int MASK_W       = 27;
   localparam int BIT_IDX_W    = 5;
   localparam int FACE_W       = 3;
   localparam int VTX_W        = 3;
   localparam int POS_W        = 6;
   localparam int ID_W         = 8;
   localparam int WORD_W       = 32;

   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
   localparam logic [VTX_W-1:0]  VTX_LAST    = 3'd5;

   localparam logic [ID_W-1:0] BLOCK_EMPTY  = 8'd0;
   localparam logic [ID_W-1:0] BLOCK_LAYERED = 8'd1;
   localparam logic [ID_W-1:0] LAYER_TOP    = 8'd0;
   localparam logic [ID_W-1:0] LAYER_BOTTOM = 8'd255;
   localparam logic [ID_W-1:0] LAYER_SIDE   = 8'd0;

   // Neighbor directly in front of each face.
   localparam logic [BIT_IDX_W-1:0] FRONT_BIT [FACE_COUNT] = '{
      5'd22, 5'd4, 5'd14, 5'd12, 5'd10, 5'd16
   };

   // Per face and corner code: side, side and diagonal neighbor bits.
   localparam logic [BIT_IDX_W-1:0] AO_BITS [FACE_COUNT][CORNER_COUNT][3] = '{
      '{'{5'd19, 5'd21, 5'd18}, '{5'd21, 5'd25, 5'd24},
        '{5'd25, 5'd23, 5'd26}, '{5'd19, 5'd23, 5'd20}},
      '{'{5'd1,  5'd3,  5'd0},  '{5'd3,  5'd7,  5'd6},
        '{5'd7,  5'd5,  5'd8},  '{5'd1,  5'd5,  5'd2}},
      '{'{5'd11, 5'd5,  5'd2},  '{5'd11, 5'd23, 5'd20},
        '{5'd23, 5'd17, 5'd26}, '{5'd17, 5'd5,  5'd8}},
      '{'{5'd9,  5'd3,  5'd0},  '{5'd9,  5'd21, 5'd18},
        '{5'd21, 5'd15, 5'd24}, '{5'd15, 5'd3,  5'd6}},
      '{'{5'd9,  5'd1,  5'd0},  '{5'd9,  5'd19, 5'd18},
        '{5'd19, 5'd11, 5'd20}, '{5'd1,  5'd11, 5'd2}},
      '{'{5'd15, 5'd7,  5'd6},  '{5'd15, 5'd25, 5'd24},
        '{5'd25, 5'd17, 5'd26}, '{5'd7,  5'd17, 5'd8}}
   };

   // Per face and corner code: vertex offset, x in bit 0, y in bit 1, z in bit 2.
   localparam logic [2:0] CORNER_POS [FACE_COUNT][CORNER_COUNT] = '{
      '{3'd2, 3'd6, 3'd7, 3'd3},
      '{3'd0, 3'd4, 3'd5, 3'd1},
      '{3'd1, 3'd3, 3'd7, 3'd5},
      '{3'd0, 3'd2, 3'd6, 3'd4},
      '{3'd0, 3'd2, 3'd3, 3'd1},
      '{3'd4, 3'd6, 3'd7, 3'd5}
   };

   // Per face: corner code order for the normal and the flipped diagonal.
   localparam logic [1:0] CORNER_SEQ [FACE_COUNT][2][VTX_PER_FACE] = '{
      '{'{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2}},
      '{'{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1}},
      '{'{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3}, '{2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd0}},
      '{'{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1}},
      '{'{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3}, '{2'd3, 2'd0, 2'd1, 2'd3, 2'd1, 2'd2}},
      '{'{2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1}}
   };

   typedef struct packed {
      logic [CORNER_COUNT-1:0][1:0] ao;
      logic                         flip;
   } face_eval_type;

   typedef struct packed {
      logic              found;
      logic [FACE_W-1:0] face;
   } face_pick_type;

   function automatic face_pick_type first_visible(input logic [FACE_COUNT-1:0] vis);
      face_pick_type pick;
      pick.found = 1'b0;
      pick.face  = '0;
      for (int i = FACE_COUNT - 1; i >= 0; i--) begin
         if (vis[i]) begin
            pick.found = 1'b1;
            pick.face  = FACE_W'(i);
         end
      end
      return pick;
   endfunction

   function automatic face_pick_type next_visible(input logic [FACE_COUNT-1:0] vis,
                                                  input logic [FACE_W-1:0]     face);
      face_pick_type pick;
      pick.found = 1'b0;
      pick.face  = '0;
      for (int i = FACE_COUNT - 1; i >= 0; i--) begin
         if (vis[i] && (FACE_W'(i) > face)) begin
            pick.found = 1'b1;
            pick.face  = FACE_W'(i);
         end
      end
      return pick;
   endfunction

endpackage

@@ hw/rtl/vfm_face_eval.sv @@
`timescale 1ns / 1ps
// Occlusion levels of the four corners of one face and the diagonal choice.
// Depends on vfm_pkg for the neighbor tables and the result struct.
module vfm_face_eval (
   input  logic [26:0]           neighbor_mask,
   input  logic [2:0]            face,
   output vfm_pkg::face_eval_type eval_out
);
   import vfm_pkg::*;

   always_comb begin
      logic       s1;
      logic       s2;
      logic       sc;
      logic [1:0] sum;
      logic [2:0] diag_a;
      logic [2:0] diag_b;
      eval_out = '0;
      for (int k = 0; k < CORNER_COUNT; k++) begin
         s1  = neighbor_mask[AO_BITS[face][k][0]];
         s2  = neighbor_mask[AO_BITS[face][k][1]];
         sc  = neighbor_mask[AO_BITS[face][k][2]];
         sum = {1'b0, s1} + {1'b0, s2} + {1'b0, sc};
         eval_out.ao[k] = (s1 && s2) ? 2'd0 : 2'd3 - sum;
      end
      diag_a = {1'b0, eval_out.ao[0]} + {1'b0, eval_out.ao[2]};
      diag_b = {1'b0, eval_out.ao[1]} + {1'b0, eval_out.ao[3]};
      eval_out.flip = (diag_a > diag_b) ? 1'b0 : 1'b1;
   end

endmodule

@@ hw/rtl/vfm_vertex_pack.sv @@
`timescale 1ns / 1ps
// Packs one vertex word from the voxel position, block id, face, vertex slot and occlusion.
// Depends on vfm_pkg for the corner tables and the face evaluation struct.
module vfm_vertex_pack (
   input  logic [5:0]             pos_x,
   input  logic [5:0]             pos_y,
   input  logic [5:0]             pos_z,
   input  logic [7:0]             block_id,
   input  logic [2:0]             face,
   input  logic [2:0]             vtx,
   input  vfm_pkg::face_eval_type eval_in,
   output logic [31:0]            vertex_word
);
   import vfm_pkg::*;

   logic [1:0]      corner;
   logic [2:0]      offset;
   logic [ID_W-1:0] layer;
   logic [POS_W-1:0] vx;
   logic [POS_W-1:0] vy;
   logic [POS_W-1:0] vz;

   assign corner = CORNER_SEQ[face][eval_in.flip][vtx];
   assign offset = CORNER_POS[face][corner];
   assign vx = pos_x + {5'b0, offset[0]};
   assign vy = pos_y + {5'b0, offset[1]};
   assign vz = pos_z + {5'b0, offset[2]};

   always_comb begin
      if (block_id == BLOCK_LAYERED) begin
         case (face)
            FACE_TOP:    layer = LAYER_TOP;
            FACE_BOTTOM: layer = LAYER_BOTTOM;
            default:     layer = LAYER_SIDE;
         endcase
      end else begin
         layer = block_id - 8'd1;
      end
   end

   assign vertex_word = {1'b0, layer, corner, {1'b0, eval_in.ao[corner]}, vz, vy, vx};

endmodule

@@ hw/rtl/voxel_face_mesher_ao.sv @@
`timescale 1ns / 1ps
// Voxel face mesher top level: input register, face and vertex sequencing, result register.
// Depends on vfm_pkg, vfm_face_eval, vfm_vertex_pack and the assertion macro header.
//
// Usage: present a voxel on the req_ ports with start high; the transaction is taken at
// the rising edge where start is high and busy is low. The voxel's vertices appear on
// rsp_vertex_word, one per cycle, each marked by rsp_strobe for exactly one cycle, with
// rsp_last_vertex high on the final one. The receiver cannot stall the block.
// Faces come in the order top, bottom, +x, -x, -z, +z; a hidden face is skipped with no
// idle cycle, and every visible face gives six vertices.
// The accepting edge loads the input and sequencer registers; each vertex is then formed
// from them and registered with rsp_strobe in the result register.
// Throughput: one vertex per cycle from the result register; a voxel gives six vertices
// per visible face, up to 36. A voxel with no visible face or block id zero gives no
// vertices and leaves busy low. busy drops in the cycle before the final vertex is
// strobed, so the next voxel is accepted as that vertex goes out and its vertices
// follow without a gap.
// Reset: synchronous and active high; it drops any voxel in progress and clears the strobe.
`include "voxel_face_mesher_ao_macros.svh"
module voxel_face_mesher_ao (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [5:0]  req_local_x,
   input  logic [5:0]  req_local_y,
   input  logic [5:0]  req_local_z,
   input  logic [7:0]  req_block_id,
   input  logic [26:0] req_neighbor_mask,
   output logic        rsp_strobe,
   output logic [31:0] rsp_vertex_word,
   output logic        rsp_last_vertex
);
   import vfm_pkg::*;

   logic                  active_ff, active_in;
   logic [FACE_W-1:0]     face_ff, face_in;
   logic [VTX_W-1:0]      vtx_ff, vtx_in;
   logic [FACE_COUNT-1:0] vis_ff, vis_in;
   logic [POS_W-1:0]      x_ff, y_ff, z_ff;
   logic [ID_W-1:0]       id_ff;
   logic [MASK_W-1:0]     mask_ff;
   logic                  strobe_ff, strobe_in;
   logic                  last_ff, last_in;
   logic [WORD_W-1:0]     word_ff, word_in;

   logic                  accept;
   logic                  face_done;
   logic                  final_vtx;
   face_pick_type         pick_next;
   face_pick_type         pick_first;
   face_eval_type         eval;

   always_comb begin
      for (int f = 0; f < FACE_COUNT; f++) begin
         vis_in[f] = (req_block_id != BLOCK_EMPTY) && !req_neighbor_mask[FRONT_BIT[f]];
      end
   end

   assign pick_first = first_visible(vis_in);
   assign pick_next  = next_visible(vis_ff, face_ff);
   assign face_done  = (vtx_ff == VTX_LAST);
   assign final_vtx  = active_ff && face_done && !pick_next.found;
   assign busy       = active_ff && !final_vtx;
   assign accept     = start && !busy;

   vfm_face_eval u_face_eval (
      .neighbor_mask (mask_ff),
      .face          (face_ff),
      .eval_out      (eval)
   );

   vfm_vertex_pack u_vertex_pack (
      .pos_x       (x_ff),
      .pos_y       (y_ff),
      .pos_z       (z_ff),
      .block_id    (id_ff),
      .face        (face_ff),
      .vtx         (vtx_ff),
      .eval_in     (eval),
      .vertex_word (word_in)
   );

   always_comb begin
      active_in = active_ff;
      face_in   = face_ff;
      vtx_in    = vtx_ff;
      if (accept) begin
         active_in = pick_first.found;
         face_in   = pick_first.face;
         vtx_in    = '0;
      end else if (active_ff) begin
         if (face_done) begin
            active_in = pick_next.found;
            face_in   = pick_next.face;
            vtx_in    = '0;
         end else begin
            vtx_in = vtx_ff + 3'd1;
         end
      end
      strobe_in = active_ff;
      last_in   = final_vtx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         face_ff   <= '0;
         vtx_ff    <= '0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         face_ff   <= face_in;
         vtx_ff    <= vtx_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_local_x;
         y_ff    <= req_local_y;
         z_ff    <= req_local_z;
         id_ff   <= req_block_id;
         mask_ff <= req_neighbor_mask;
         vis_ff  <= vis_in;
      end
      word_ff <= word_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_vertex_word = word_ff;
   assign rsp_last_vertex = last_ff;

   `VFM_ASSERT_NEXT(a_final_marked, clock, reset, final_vtx, strobe_ff && last_ff,
      "final vertex of a voxel was not strobed as last")
   `VFM_ASSERT_SAME(a_face_visible, clock, reset, active_ff, vis_ff[face_ff],
      "sequencer is emitting a hidden face")
   `VFM_ASSERT_NEXT(a_no_face_idle, clock, reset, accept && !pick_first.found, !active_ff,
      "voxel with no visible face started emitting")
   `VFM_ASSERT_SAME(a_mid_voxel_active, clock, reset, strobe_ff && !last_ff, active_ff,
      "sequencer stopped before the last vertex of a voxel")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for voxel_face_mesher_ao: a directed table, then bursts of random voxels.
// Depends on the block's RTL only; every vertex is checked against a local face predictor.
module tb_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_VOXELS = 460;

   localparam logic [7:0] ID_EMPTY = 8'd0;
   localparam logic [7:0] ID_LAYERED = 8'd1;
   localparam logic [7:0] LAYER_UP = 8'd0;
   localparam logic [7:0] LAYER_DOWN = 8'd255;
   localparam logic [7:0] LAYER_SIDE = 8'd0;
   localparam int FACE_UP = 0;
   localparam int FACE_DOWN = 1;

   localparam logic [26:0] ALL_SOLID = 27'h7FFFFFF;
   localparam logic [26:0] BURIED_MASK = 27'h0415410;

   // Outward normal of each face as x, y, z.
   localparam int NORMAL_DIR [6][3] = '{
      '{0, 1, 0}, '{0, -1, 0}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 0, -1}, '{0, 0, 1}
   };

   // Vertex offset as x, y, z for each face and corner code.
   localparam int CORNER_OFS [6][4][3] = '{
      '{'{0, 1, 0}, '{0, 1, 1}, '{1, 1, 1}, '{1, 1, 0}},
      '{'{0, 0, 0}, '{0, 0, 1}, '{1, 0, 1}, '{1, 0, 0}},
      '{'{1, 0, 0}, '{1, 1, 0}, '{1, 1, 1}, '{1, 0, 1}},
      '{'{0, 0, 0}, '{0, 1, 0}, '{0, 1, 1}, '{0, 0, 1}},
      '{'{0, 0, 0}, '{0, 1, 0}, '{1, 1, 0}, '{1, 0, 0}},
      '{'{0, 0, 1}, '{0, 1, 1}, '{1, 1, 1}, '{1, 0, 1}}
   };

   localparam int QUAD_ORDER [6][2][6] = '{
      '{'{0, 1, 2, 0, 2, 3}, '{3, 0, 1, 3, 1, 2}},
      '{'{0, 2, 1, 0, 3, 2}, '{3, 1, 0, 3, 2, 1}},
      '{'{0, 1, 2, 0, 2, 3}, '{1, 2, 3, 1, 3, 0}},
      '{'{0, 2, 1, 0, 3, 2}, '{3, 1, 0, 3, 2, 1}},
      '{'{0, 1, 2, 0, 2, 3}, '{3, 0, 1, 3, 1, 2}},
      '{'{0, 2, 1, 0, 3, 2}, '{3, 1, 0, 3, 2, 1}}
   };

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } mesh_vertex_type;

   typedef struct packed {
      bit [5:0]  x;
      bit [5:0]  y;
      bit [5:0]  z;
      bit [7:0]  id;
      bit [26:0] mask;
      bit        silent;
   } voxel_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam voxel_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{6'd0,  6'd0,  6'd0,  8'd0,   27'h0000000, 1'b1},
      '{6'd62, 6'd62, 6'd62, 8'd0,   ALL_SOLID,   1'b1},
      '{6'd5,  6'd6,  6'd7,  8'd9,   ALL_SOLID,   1'b1},
      '{6'd5,  6'd6,  6'd7,  8'd9,   BURIED_MASK, 1'b1},
      '{6'd0,  6'd0,  6'd0,  8'd1,   27'h0000000, 1'b0},
      '{6'd62, 6'd62, 6'd62, 8'd255, 27'h0000000, 1'b0},
      '{6'd63, 6'd63, 6'd63, 8'd2,   27'h0000000, 1'b0},
      '{6'd63, 6'd0,  6'd63, 8'd1,   27'h7BFFFFF, 1'b0},
      '{6'd1,  6'd2,  6'd3,  8'd1,   27'h0015410, 1'b0},
      '{6'd1,  6'd2,  6'd3,  8'd1,   27'h0415400, 1'b0},
      '{6'd1,  6'd2,  6'd3,  8'd1,   27'h0411410, 1'b0},
      '{6'd4,  6'd5,  6'd6,  8'd128, 27'h0414410, 1'b0},
      '{6'd4,  6'd5,  6'd6,  8'd128, 27'h0415010, 1'b0},
      '{6'd4,  6'd5,  6'd6,  8'd128, 27'h0405410, 1'b0},
      '{6'd10, 6'd20, 6'd30, 8'd254, 27'h0000001, 1'b0},
      '{6'd10, 6'd20, 6'd30, 8'd3,   27'h4000000, 1'b0},
      '{6'd31, 6'd31, 6'd31, 8'd7,   27'h0080000, 1'b0},
      '{6'd31, 6'd31, 6'd31, 8'd7,   27'h0280000, 1'b0},
      '{6'd42, 6'd21, 6'd0,  8'd85,  27'h2AAAAAA, 1'b0},
      '{6'd21, 6'd42, 6'd63, 8'd170, 27'h5555555, 1'b0},
      '{6'd0,  6'd63, 6'd0,  8'd1,   27'h7BEBBEF, 1'b0},
      '{6'd62, 6'd1,  6'd62, 8'd2,   27'h0E0E0E0, 1'b0}
   };

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [5:0]  req_local_x;
   logic [5:0]  req_local_y;
   logic [5:0]  req_local_z;
   logic [7:0]  req_block_id;
   logic [26:0] req_neighbor_mask;
   logic        rsp_strobe;
   logic [31:0] rsp_vertex_word;
   logic        rsp_last_vertex;

   bit              row_silent;
   int              mismatch_count;
   int              cycle_count;
   mesh_vertex_type pending_vertices [$];
   mesh_vertex_type oldest_vertex;

   voxel_face_mesher_ao dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_local_x       (req_local_x),
      .req_local_y       (req_local_y),
      .req_local_z       (req_local_z),
      .req_block_id      (req_block_id),
      .req_neighbor_mask (req_neighbor_mask),
      .rsp_strobe        (rsp_strobe),
      .rsp_vertex_word   (rsp_vertex_word),
      .rsp_last_vertex   (rsp_last_vertex)
   );

   function automatic int nb(input int dx, input int dy, input int dz);
      return (dy + 1) * 9 + (dz + 1) * 3 + (dx + 1);
   endfunction

   // Appends the vertices that one voxel produces to pending_vertices.
   function automatic void mesh_voxel(input logic [5:0] vx, input logic [5:0] vy,
                                      input logic [5:0] vz, input logic [7:0] id,
                                      input logic [26:0] mask);
      int d [3];
      int s1 [3];
      int s2 [3];
      int ao [4];
      int tang [2];
      int nt;
      int side_a;
      int side_b;
      int diag;
      int flip;
      int c;
      int first_new;
      logic [7:0] layer;
      logic [5:0] wx;
      logic [5:0] wy;
      logic [5:0] wz;
      mesh_vertex_type v;
      first_new = pending_vertices.size();
      if (id == ID_EMPTY) return;
      for (int f = 0; f < 6; f++) begin
         if (mask[nb(NORMAL_DIR[f][0], NORMAL_DIR[f][1], NORMAL_DIR[f][2])]) continue;
         nt = 0;
         for (int a = 0; a < 3; a++) begin
            if (NORMAL_DIR[f][a] == 0) begin
               tang[nt] = a;
               nt++;
            end
         end
         for (int k = 0; k < 4; k++) begin
            for (int a = 0; a < 3; a++) begin
               if (NORMAL_DIR[f][a] != 0) d[a] = NORMAL_DIR[f][a];
               else d[a] = (CORNER_OFS[f][k][a] != 0) ? 1 : -1;
            end
            s1 = d;
            s1[tang[0]] = 0;
            s2 = d;
            s2[tang[1]] = 0;
            side_a = mask[nb(s1[0], s1[1], s1[2])];
            side_b = mask[nb(s2[0], s2[1], s2[2])];
            diag = mask[nb(d[0], d[1], d[2])];
            ao[k] = (side_a != 0 && side_b != 0) ? 0 : 3 - (side_a + side_b + diag);
         end
         flip = (ao[0] + ao[2] > ao[1] + ao[3]) ? 0 : 1;
         if (id == ID_LAYERED) begin
            layer = (f == FACE_UP) ? LAYER_UP : (f == FACE_DOWN) ? LAYER_DOWN : LAYER_SIDE;
         end else begin
            layer = id - 8'd1;
         end
         for (int k = 0; k < 6; k++) begin
            c = QUAD_ORDER[f][flip][k];
            wx = vx + 6'(CORNER_OFS[f][c][0]);
            wy = vy + 6'(CORNER_OFS[f][c][1]);
            wz = vz + 6'(CORNER_OFS[f][c][2]);
            v.word = {1'b0, layer, 2'(c), 3'(ao[c]), wz, wy, wx};
            v.last = 1'b0;
            pending_vertices.push_back(v);
         end
      end
      if (pending_vertices.size() > first_new) pending_vertices[$].last = 1'b1;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d vertices outstanding", $time, pending_vertices.size());
         $display("** voxel_face_mesher_ao: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_vertices.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected vertex: expected none, actual word %h last %b",
                        $time, rsp_vertex_word, rsp_last_vertex);
            end else begin
               oldest_vertex = pending_vertices.pop_front();
               if (rsp_vertex_word !== oldest_vertex.word) begin
                  mismatch_count++;
                  $display("%0t: vertex_word mismatch: expected %h, actual %h",
                           $time, oldest_vertex.word, rsp_vertex_word);
               end
               if (rsp_last_vertex !== oldest_vertex.last) begin
                  mismatch_count++;
                  $display("%0t: last_vertex mismatch: expected %b, actual %b",
                           $time, oldest_vertex.last, rsp_last_vertex);
               end
            end
         end
         if (start && !busy && !row_silent) begin
            mesh_voxel(req_local_x, req_local_y, req_local_z, req_block_id, req_neighbor_mask);
         end
      end
   end

   task automatic drive_voxel(input logic [5:0] x, input logic [5:0] y, input logic [5:0] z,
                              input logic [7:0] id, input logic [26:0] mask, input bit silent);
      @(negedge clock);
      req_local_x = x;
      req_local_y = y;
      req_local_z = z;
      req_block_id = id;
      req_neighbor_mask = mask;
      row_silent = silent;
      start = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_cycles(input int n);
      @(negedge clock);
      start = 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_vertices();
      @(negedge clock);
      start = 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
   endtask

   initial begin
      int burst_left;
      int gap;
      int face;
      logic [7:0] id;
      logic [26:0] mask;
      logic [26:0] ra;
      logic [26:0] rb;
      reset = 1'b1;
      start = 1'b0;
      req_local_x = '0;
      req_local_y = '0;
      req_local_z = '0;
      req_block_id = '0;
      req_neighbor_mask = '0;
      row_silent = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      burst_left = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         drive_voxel(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z, DIRECTED[i].id,
                     DIRECTED[i].mask, DIRECTED[i].silent);
      end
      drain_vertices();

      for (int i = 0; i < RANDOM_VOXELS; i++) begin
         if (i == RANDOM_VOXELS / 2) drain_vertices();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) pause_cycles(gap);
         end
         burst_left--;
         case ($urandom_range(0, 19))
            0: id = ID_EMPTY;
            1, 2: id = ID_LAYERED;
            default: id = 8'($urandom_range(0, 255));
         endcase
         ra = 27'($urandom);
         rb = 27'($urandom);
         case ($urandom_range(0, 3))
            0: mask = ra & rb;
            1: mask = ra | rb;
            2: mask = ra;
            default: begin
               face = $urandom_range(0, 5);
               mask = (BURIED_MASK | (ra & rb))
                      & ~(27'd1 << nb(NORMAL_DIR[face][0], NORMAL_DIR[face][1],
                                      NORMAL_DIR[face][2]));
            end
         endcase
         drive_voxel(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)), id, mask, 1'b0);
      end

      drain_vertices();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** voxel_face_mesher_ao: PASSED **");
      end else begin
         $display("** voxel_face_mesher_ao: FAILED **");
      end
      $finish;
   end

endmodule
